@@ rtl/core/wlm_pkg.sv @@
package wlm_pkg;

  localparam int HISTORY_DEPTH_DEF = 64;

  localparam int OP_W    = 2;
  localparam int STAMP_W = 48;
  localparam int IVAL_W  = 32;
  localparam int LOAD_W  = 7;
  localparam int LIMIT_W = 7;
  localparam int CFG_W   = 32;
  localparam int ADDR_W  = 3;

  localparam logic [CFG_W-1:0]   WINDOW_RESET = 32'd1000000;
  localparam logic [LIMIT_W-1:0] ENTRY_RESET  = 7'd64;

  // event codes
  localparam logic [OP_W-1:0] OP_SLEEP = 2'd0;
  localparam logic [OP_W-1:0] OP_WAKE  = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd2;
  localparam logic [OP_W-1:0] OP_NONE  = 2'd3;

  // register index, taken from paddr[2]
  localparam logic REG_WINDOW = 1'b0;
  localparam logic REG_ENTRY  = 1'b1;

  typedef struct packed {
    logic       capture;
    logic       span;
    logic       push;
    logic       pop;
    logic       qsum;
    logic       mul;
    logic       div;
    logic [2:0] div_shift;
    logic       load;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            count_full;
    logic            over_limit;
    logic            evict_needed;
    logic            out_free;
  } stat_t;

endpackage

@@ rtl/core/wlm_if.sv @@
interface wlm_item_if;
  import wlm_pkg::*;
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    op;
  logic [STAMP_W-1:0] now_us;
  modport source (output valid, output op, output now_us, input ready);
  modport sink   (input valid, input op, input now_us, output ready);
endinterface

interface wlm_result_if;
  import wlm_pkg::*;
  logic              valid;
  logic              ready;
  logic [LOAD_W-1:0] load_percent;
  modport source (output valid, output load_percent, input ready);
  modport sink   (input valid, input load_percent, output ready);
endinterface

@@ rtl/core/wlm_ctrl.sv @@
module wlm_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  wlm_pkg::stat_t stat,
  output wlm_pkg::cmd_t  cmd
);
  import wlm_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_SPAN     = 4'd1;
  localparam logic [3:0] S_PUSH     = 4'd2;
  localparam logic [3:0] S_PUSH_CHK = 4'd3;
  localparam logic [3:0] S_POP_WAIT = 4'd4;
  localparam logic [3:0] S_POP_DO   = 4'd5;
  localparam logic [3:0] S_Q_SUM    = 4'd6;
  localparam logic [3:0] S_EV_CHK   = 4'd7;
  localparam logic [3:0] S_MUL      = 4'd8;
  localparam logic [3:0] S_DIV      = 4'd9;
  localparam logic [3:0] S_OUT      = 4'd10;

  localparam logic [2:0] STEP_TOP = 3'(LOAD_W - 1);

  logic [3:0] state_r, state_nxt;
  logic [3:0] ret_r, ret_nxt;
  logic [2:0] step_r, step_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    step_nxt  = step_r;
    cmd       = '0;
    cmd.div_shift = step_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_SPAN;
        end
      end
      S_SPAN: begin
        cmd.span = 1'b1;
        if (stat.op == OP_SLEEP || stat.op == OP_WAKE) begin
          if (stat.count_full) begin
            // ring full: drop the oldest record before the push
            ret_nxt   = S_PUSH;
            state_nxt = S_POP_WAIT;
          end else begin
            state_nxt = S_PUSH;
          end
        end else if (stat.op == OP_QUERY) begin
          state_nxt = S_Q_SUM;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_PUSH: begin
        cmd.push  = 1'b1;
        state_nxt = S_PUSH_CHK;
      end
      S_PUSH_CHK: begin
        if (stat.over_limit) begin
          ret_nxt   = S_IDLE;
          state_nxt = S_POP_WAIT;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_POP_WAIT: begin
        // ring read of the head entry lands at the end of this cycle
        state_nxt = S_POP_DO;
      end
      S_POP_DO: begin
        cmd.pop   = 1'b1;
        state_nxt = ret_r;
      end
      S_Q_SUM: begin
        cmd.qsum  = 1'b1;
        state_nxt = S_EV_CHK;
      end
      S_EV_CHK: begin
        if (stat.evict_needed) begin
          ret_nxt   = S_EV_CHK;
          state_nxt = S_POP_WAIT;
        end else begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        step_nxt  = STEP_TOP;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div = 1'b1;
        if (step_r == 3'd0) begin
          state_nxt = S_OUT;
        end else begin
          step_nxt = step_r - 3'd1;
        end
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ret_r   <= S_IDLE;
      step_r  <= 3'd0;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      step_r  <= step_nxt;
    end
  end

endmodule

@@ rtl/core/wlm_datapath.sv @@
module wlm_datapath #(
  parameter int HISTORY_DEPTH = wlm_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  wlm_pkg::cmd_t                 cmd,
  output wlm_pkg::stat_t                stat,
  input  logic [wlm_pkg::OP_W-1:0]      in_op,
  input  logic [wlm_pkg::STAMP_W-1:0]   in_now_us,
  input  logic [wlm_pkg::CFG_W-1:0]     window_limit,
  input  logic [wlm_pkg::LIMIT_W-1:0]   entry_limit,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [wlm_pkg::LOAD_W-1:0]    out_load_percent
);
  import wlm_pkg::*;

  localparam int IDX_W = $clog2(HISTORY_DEPTH);
  localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
  localparam int SUM_W = IVAL_W + CNT_W;
  localparam int TOT_W = SUM_W + 1;
  localparam int REM_W = TOT_W + LOAD_W;
  localparam int REC_W = IVAL_W + 1;

  localparam logic [IDX_W:0]   DEPTH_EXT = (IDX_W + 1)'(HISTORY_DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(HISTORY_DEPTH);
  localparam logic [IDX_W-1:0] HEAD_LAST = IDX_W'(HISTORY_DEPTH - 1);

  logic [REC_W-1:0] ring_mem [HISTORY_DEPTH];
  logic [REC_W-1:0] rd_r;

  logic [IDX_W-1:0]   head_r;
  logic [CNT_W-1:0]   count_r;
  logic               sleeping_r;
  logic [STAMP_W-1:0] sleep_stamp_r;
  logic [STAMP_W-1:0] wake_stamp_r;
  logic [SUM_W-1:0]   run_sum_r;
  logic [SUM_W-1:0]   sleep_sum_r;

  logic [OP_W-1:0]    op_r;
  logic [STAMP_W-1:0] now_r;
  logic [IVAL_W-1:0]  span_r;
  logic [TOT_W-1:0]   run_r;
  logic [TOT_W-1:0]   total_r;
  logic [REM_W-1:0]   rem_r;
  logic [LOAD_W-1:0]  quot_r;
  logic               out_valid_r;
  logic [LOAD_W-1:0]  out_pct_r;

  logic [STAMP_W-1:0] span_from;
  logic [STAMP_W-1:0] span_diff;
  logic [IVAL_W-1:0]  span_val;
  logic [IDX_W:0]     slot_sum;
  logic [IDX_W-1:0]   slot;
  logic               rec_sleep;
  logic [REC_W-1:0]   wdata;
  logic [IVAL_W-1:0]  pop_t;
  logic [REM_W-1:0]   div_cand;
  logic               over_limit;

  // closing stamp: sleep closes a run from the wake stamp, wake closes a sleep; a query measures the open interval
  always_comb begin
    if (op_r == OP_SLEEP) begin
      span_from = wake_stamp_r;
    end else if (op_r == OP_WAKE) begin
      span_from = sleep_stamp_r;
    end else if (sleeping_r) begin
      span_from = sleep_stamp_r;
    end else begin
      span_from = wake_stamp_r;
    end
    span_diff = now_r - span_from;
    if (now_r < span_from) begin
      span_val = '0;
    end else if (span_diff[STAMP_W-1:IVAL_W] != '0) begin
      span_val = '1;
    end else begin
      span_val = span_diff[IVAL_W-1:0];
    end
  end

  assign slot_sum  = (IDX_W + 1)'(head_r) + (IDX_W + 1)'(count_r);
  assign slot      = (slot_sum >= DEPTH_EXT) ? IDX_W'(slot_sum - DEPTH_EXT)
                                             : slot_sum[IDX_W-1:0];
  assign rec_sleep = (op_r == OP_WAKE);
  assign wdata     = {rec_sleep, span_r};
  assign pop_t     = rd_r[IVAL_W-1:0];
  assign div_cand  = REM_W'(total_r) << cmd.div_shift;
  // limits above the ring depth never trip since the count stays within it
  assign over_limit = 32'(count_r) > 32'(entry_limit);

  assign stat.op           = op_r;
  assign stat.count_full   = (count_r == DEPTH_CNT);
  assign stat.over_limit   = over_limit;
  assign stat.evict_needed = (count_r != '0) &&
                             ((total_r > TOT_W'(window_limit)) || over_limit);
  assign stat.out_free     = !out_valid_r || out_ready;

  assign out_valid        = out_valid_r;
  assign out_load_percent = out_pct_r;

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      ring_mem[slot] <= wdata;
    end
    rd_r <= ring_mem[head_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r        <= '0;
      count_r       <= '0;
      sleeping_r    <= 1'b0;
      sleep_stamp_r <= '0;
      wake_stamp_r  <= '0;
      run_sum_r     <= '0;
      sleep_sum_r   <= '0;
    end else if (cmd.push) begin
      count_r    <= count_r + CNT_W'(1);
      sleeping_r <= (op_r == OP_SLEEP);
      if (rec_sleep) begin
        sleep_sum_r  <= sleep_sum_r + SUM_W'(span_r);
        wake_stamp_r <= now_r;
      end else begin
        run_sum_r     <= run_sum_r + SUM_W'(span_r);
        sleep_stamp_r <= now_r;
      end
    end else if (cmd.pop) begin
      head_r  <= (head_r == HEAD_LAST) ? '0 : head_r + IDX_W'(1);
      count_r <= count_r - CNT_W'(1);
      if (rd_r[IVAL_W]) begin
        sleep_sum_r <= sleep_sum_r - SUM_W'(pop_t);
      end else begin
        run_sum_r <= run_sum_r - SUM_W'(pop_t);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r  <= in_op;
      now_r <= in_now_us;
    end
    if (cmd.span) begin
      span_r <= span_val;
    end
    if (cmd.qsum) begin
      run_r   <= TOT_W'(run_sum_r) + (sleeping_r ? '0 : TOT_W'(span_r));
      total_r <= TOT_W'(run_sum_r) + TOT_W'(sleep_sum_r) + TOT_W'(span_r);
    end else if (cmd.pop) begin
      if (!rd_r[IVAL_W]) begin
        run_r <= run_r - TOT_W'(pop_t);
      end
      total_r <= total_r - TOT_W'(pop_t);
    end
    // times 100 as 64 + 32 + 4
    if (cmd.mul) begin
      rem_r  <= (REM_W'(run_r) << 6) + (REM_W'(run_r) << 5) + (REM_W'(run_r) << 2);
      quot_r <= '0;
    end else if (cmd.div) begin
      if (rem_r >= div_cand) begin
        rem_r <= rem_r - div_cand;
        quot_r[cmd.div_shift] <= 1'b1;
      end
    end
    if (cmd.load) begin
      out_pct_r <= (total_r == '0) ? '0 : quot_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

endmodule

@@ rtl/core/windowed_load_monitor.sv @@
// windowed load monitor: duty cycle of a scheduler over a sliding window
// in_ch carries one item per event: op (sleep, wake, query) and now_us.
// sleep and wake close the open interval into a history ring and give no
// result; a query gives one load_percent item on out_ch, run share 0..100.
// window_limit_us and entry_limit are to be written by the user over the
// apb port at byte addresses 0 and 4 only while the block is idle; the
// block does not enforce this. both read back. one item at a time:
// in_ch.ready is high only while the controller idles. a sleep or wake
// item drops the oldest record if the ring is full, is pushed, and drops
// one more if over entry_limit. a query sums, evicts oldest records while
// over either limit through the single ring read port, scales by 100 and
// runs the 7-step shift-subtract divider. the result sits in an output
// register; a stalled receiver holds the next query, earlier items flow.
// reset (synchronous, rst_n low) empties the ring, clears sums and stamps,
// marks the block running and restores both limits; no clearing pass.
module windowed_load_monitor #(
  parameter int HISTORY_DEPTH = wlm_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  wlm_item_if.sink                     in_ch,
  wlm_result_if.source                 out_ch,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [wlm_pkg::ADDR_W-1:0]   paddr,
  input  logic [wlm_pkg::CFG_W-1:0]    pwdata,
  output logic [wlm_pkg::CFG_W-1:0]    prdata,
  output logic                         pready
);
  import wlm_pkg::*;

  logic [CFG_W-1:0]   window_r;
  logic [LIMIT_W-1:0] entry_limit_r;
  logic               cfg_wr;
  logic               in_ready;
  cmd_t               cmd;
  stat_t              stat;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_ENTRY) ? CFG_W'(entry_limit_r) : window_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r      <= WINDOW_RESET;
      entry_limit_r <= ENTRY_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_WINDOW) begin
        window_r <= pwdata;
      end else begin
        entry_limit_r <= pwdata[LIMIT_W-1:0];
      end
    end
  end

  assign in_ch.ready = in_ready;

  wlm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  wlm_datapath #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_op            (in_ch.op),
    .in_now_us        (in_ch.now_us),
    .window_limit     (window_r),
    .entry_limit      (entry_limit_r),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_load_percent (out_ch.load_percent)
  );

endmodule

@@ tb/tb_windowed_load_monitor.sv @@
module tb_windowed_load_monitor;
  timeunit 1ns;
  timeprecision 1ps;

  import wlm_pkg::*;

  localparam int HIST_DEPTH    = HISTORY_DEPTH_DEF;
  // settle time for the longest query, one that evicts every record, with some margin
  localparam int SETTLE_CYCLES = 13 + 3 * HIST_DEPTH + 40;
  localparam int STALL_LIMIT   = 5000;
  localparam int REPORT_MAX    = 10;
  localparam int HOLD_OFF_LONG = 400;

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [CFG_W-1:0]  pwdata;
  logic [CFG_W-1:0]  prdata;
  logic              pready;

  wlm_item_if   in_bus ();
  wlm_result_if out_bus ();

  windowed_load_monitor #(
    .HISTORY_DEPTH(HIST_DEPTH)
  ) uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_bus),
    .out_ch  (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // predicted block state
  logic [IVAL_W:0]    ring_copy [HIST_DEPTH];
  int unsigned        oldest_slot;
  int unsigned        held_records;
  bit                 asleep;
  logic [STAMP_W-1:0] slept_at;
  logic [STAMP_W-1:0] woke_at;
  longint unsigned    run_total;
  longint unsigned    sleep_total;
  logic [CFG_W-1:0]   window_us;
  logic [LIMIT_W-1:0] entry_cap;

  logic [LOAD_W-1:0]  expected_loads [$];
  logic [LOAD_W-1:0]  want_load;

  logic [STAMP_W-1:0] stamp_now;
  int unsigned        src_idle_pct;
  int unsigned        sink_idle_pct;
  int unsigned        hold_off_left;
  int unsigned        quiet_cycles;
  int unsigned        fail_count;
  int unsigned        events_sent;
  int unsigned        queries_sent;
  int unsigned        results_seen;
  int unsigned        reg_writes;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void note_failure(input string msg);
    fail_count++;
    if (fail_count <= REPORT_MAX) begin
      $display("%0t: %s", $time, msg);
    end
  endfunction

  function automatic void reset_model();
    oldest_slot  = 0;
    held_records = 0;
    asleep       = 1'b0;
    slept_at     = '0;
    woke_at      = '0;
    run_total    = 0;
    sleep_total  = 0;
    window_us    = WINDOW_RESET;
    entry_cap    = ENTRY_RESET;
  endfunction

  // interval length, zero when the end precedes the start, capped at 32 bits
  function automatic longint unsigned clipped_span(input logic [STAMP_W-1:0] from,
                                                   input logic [STAMP_W-1:0] upto);
    longint unsigned d;
    if (upto < from) begin
      return 0;
    end
    d = upto - from;
    return (d > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : d;
  endfunction

  function automatic int unsigned record_cap();
    return (entry_cap > HIST_DEPTH) ? HIST_DEPTH : int'(entry_cap);
  endfunction

  function automatic longint unsigned drop_oldest();
    logic [IVAL_W:0] rec;
    longint unsigned t;
    if (held_records == 0) begin
      return 0;
    end
    rec = ring_copy[oldest_slot];
    t   = rec[IVAL_W-1:0];
    if (rec[IVAL_W]) begin
      sleep_total -= t;
    end else begin
      run_total -= t;
    end
    oldest_slot = (oldest_slot + 1) % HIST_DEPTH;
    held_records--;
    return t;
  endfunction

  function automatic void add_record(input longint unsigned t, input bit is_sleep);
    if (held_records >= HIST_DEPTH) begin
      void'(drop_oldest());
    end
    ring_copy[(oldest_slot + held_records) % HIST_DEPTH] = {is_sleep, t[IVAL_W-1:0]};
    if (is_sleep) begin
      sleep_total += t;
    end else begin
      run_total += t;
    end
    held_records++;
    if (held_records > record_cap()) begin
      void'(drop_oldest());
    end
  endfunction

  function automatic void predict_load(input logic [OP_W-1:0] op,
                                       input logic [STAMP_W-1:0] stamp);
    longint unsigned run_part;
    longint unsigned total;
    longint unsigned open_span;
    longint unsigned t;
    longint unsigned pct;
    bit              oldest_sleep;
    case (op)
      OP_SLEEP: begin
        asleep = 1'b1;
        add_record(clipped_span(woke_at, stamp), 1'b0);
        slept_at = stamp;
      end
      OP_WAKE: begin
        asleep = 1'b0;
        add_record(clipped_span(slept_at, stamp), 1'b1);
        woke_at = stamp;
      end
      OP_QUERY: begin
        run_part = run_total;
        if (asleep) begin
          open_span = clipped_span(slept_at, stamp);
        end else begin
          open_span = clipped_span(woke_at, stamp);
          run_part += open_span;
        end
        total = run_total + sleep_total + open_span;
        while (held_records != 0 && (total > window_us || held_records > record_cap())) begin
          oldest_sleep = ring_copy[oldest_slot][IVAL_W];
          t = drop_oldest();
          if (!oldest_sleep) begin
            run_part -= t;
          end
          total -= t;
        end
        pct = (total == 0) ? 0 : (run_part * 100) / total;
        expected_loads.push_back(pct[LOAD_W-1:0]);
      end
      default: begin
      end
    endcase
  endfunction

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready) begin
      results_seen++;
      if (expected_loads.size() == 0) begin
        note_failure($sformatf("load_percent %0d with no query pending", out_bus.load_percent));
      end else begin
        want_load = expected_loads[0];
        expected_loads.delete(0);
        if (out_bus.load_percent !== want_load) begin
          note_failure($sformatf("load_percent: expected %0d, got %0d",
                                 want_load, out_bus.load_percent));
        end
      end
    end
  end

  // receiver: random stalls, or a counted hold-off when one is requested
  initial begin
    out_bus.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_left > 0) begin
        out_bus.ready <= 1'b0;
        hold_off_left--;
      end else begin
        out_bus.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
        (psel && penable)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("no item moved for %0d cycles, %0d results outstanding",
                 quiet_cycles, expected_loads.size());
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  task automatic send_event(input logic [OP_W-1:0] op, input logic [STAMP_W-1:0] stamp);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(negedge clk);
    end
    in_bus.valid  <= 1'b1;
    in_bus.op     <= op;
    in_bus.now_us <= stamp;
    @(posedge clk);
    while (!in_bus.ready) begin
      @(posedge clk);
    end
    predict_load(op, stamp);
    events_sent++;
    if (op == OP_QUERY) begin
      queries_sent++;
    end
  endtask

  // wait out every pending load and the tail of any sleep or wake in flight
  task automatic drain_block();
    @(negedge clk);
    in_bus.valid <= 1'b0;
    while (expected_loads.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic sel, input logic [CFG_W-1:0] value);
    logic [CFG_W-1:0] readback;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) begin
      @(posedge clk);
    end
    if (sel == REG_WINDOW) begin
      window_us = value;
    end else begin
      entry_cap = value[LIMIT_W-1:0];
    end
    reg_writes++;
    // read it back
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) begin
      @(posedge clk);
    end
    readback = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (sel == REG_WINDOW && readback !== value) begin
      note_failure($sformatf("window_limit_us read: expected %0d, got %0d", value, readback));
    end else if (sel == REG_ENTRY && readback[LIMIT_W-1:0] !== value[LIMIT_W-1:0]) begin
      note_failure($sformatf("entry_limit read: expected %0d, got %0d",
                             value[LIMIT_W-1:0], readback[LIMIT_W-1:0]));
    end
  endtask

  task automatic set_limits(input logic [CFG_W-1:0] window, input logic [LIMIT_W-1:0] entries);
    drain_block();
    write_reg(REG_WINDOW, window);
    write_reg(REG_ENTRY, {{(CFG_W-LIMIT_W){1'b0}}, entries});
  endtask

  function automatic void advance_stamp();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 78) begin
      stamp_now += STAMP_W'($urandom_range(60000));
    end else if (r < 86) begin
      // same timestamp again
    end else if (r < 92) begin
      stamp_now -= STAMP_W'($urandom_range(100000));
    end else if (r < 98) begin
      stamp_now += STAMP_W'({2'($urandom), 32'($urandom)});
    end else begin
      stamp_now = {16'($urandom), 32'($urandom)};
    end
  endfunction

  // mostly alternating sleep and wake with queries between, some repeats and noise
  task automatic send_random_event();
    logic [OP_W-1:0] op;
    int unsigned     r;
    advance_stamp();
    r = $urandom_range(99);
    if (r < 38) begin
      op = asleep ? OP_WAKE : OP_SLEEP;
    end else if (r < 46) begin
      op = asleep ? OP_SLEEP : OP_WAKE;
    end else if (r < 97) begin
      op = OP_QUERY;
    end else begin
      op = OP_NONE;
    end
    send_event(op, stamp_now);
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] window, input logic [LIMIT_W-1:0] entries,
                           input int unsigned n);
    set_limits(window, entries);
    repeat (n) send_random_event();
  endtask

  function automatic logic [CFG_W-1:0] pick_window();
    case ($urandom_range(5))
      0:       return '0;
      1:       return 32'd1;
      2:       return $urandom_range(200000, 1);
      3:       return WINDOW_RESET;
      4:       return $urandom;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  function automatic logic [LIMIT_W-1:0] pick_entries();
    case ($urandom_range(5))
      0:       return '0;
      1:       return 7'd1;
      2:       return 7'($urandom_range(63, 2));
      3:       return 7'd64;
      4:       return 7'($urandom_range(127, 65));
      default: return 7'($urandom_range(64, 1));
    endcase
  endfunction

  task automatic test_directed_events();
    send_event(OP_QUERY, 48'd0);
    send_event(OP_SLEEP, 48'd100);
    send_event(OP_QUERY, 48'd150);
    send_event(OP_WAKE,  48'd400);
    send_event(OP_QUERY, 48'd400);
    // repeated wake, a sleep that lands before the last wake, then a repeated sleep
    send_event(OP_WAKE,  48'd500);
    send_event(OP_SLEEP, 48'd450);
    send_event(OP_SLEEP, 48'd900);
    send_event(OP_QUERY, 48'd800);
    send_event(OP_NONE,  48'hFFFF_FFFF_FFFF);
    send_event(OP_QUERY, 48'hFFFF_FFFF_FFFF);
    send_event(OP_WAKE,  48'hFFFF_FFFF_FFFF);
    send_event(OP_QUERY, 48'h8000_0000_0000);
    send_event(OP_SLEEP, 48'hFFFF_FFFF_FFFF);
    send_event(OP_WAKE,  48'h0);
    // open run interval past 32 bits saturates
    send_event(OP_QUERY, 48'h0001_0000_0000);
    send_event(OP_SLEEP, 48'h5555_5555_5555);
    send_event(OP_QUERY, 48'h5555_5555_5555 + 48'd1000);
    send_event(OP_WAKE,  48'hAAAA_AAAA_AAAA);
    send_event(OP_NONE,  48'h0);
    send_event(OP_QUERY, 48'hAAAA_AAAA_AAAA + 48'd250000);
    stamp_now = 48'hAAAA_AAAA_AAAA + 48'd250000;
  endtask

  task automatic test_limit_extremes();
    // entry limit above the ring depth, long enough to wrap the ring
    run_phase(32'hFFFF_FFFF, 7'd127, 130);
    // limit lowered well below the records held
    run_phase(32'd150000, 7'd2, 80);
    run_phase('0, '0, 70);
    run_phase(32'd1, 7'd1, 70);
  endtask

  task automatic test_back_pressure();
    set_limits(WINDOW_RESET, ENTRY_RESET);
    hold_off_left = HOLD_OFF_LONG;
    repeat (30) send_random_event();
    drain_block();
  endtask

  task automatic test_no_idle_stretch();
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    run_phase(pick_window(), pick_entries(), 100);
    drain_block();
    src_idle_pct  = 27;
    sink_idle_pct = 27;
  endtask

  task automatic test_random_settings();
    repeat (3) run_phase(pick_window(), pick_entries(), 70);
  endtask

  initial begin
    rst_n          <= 1'b0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    in_bus.valid   <= 1'b0;
    in_bus.op      <= OP_NONE;
    in_bus.now_us  <= '0;
    reset_model();
    stamp_now     = '0;
    src_idle_pct  = 27;
    sink_idle_pct = 27;
    hold_off_left = 0;
    quiet_cycles  = 0;
    fail_count    = 0;
    events_sent   = 0;
    queries_sent  = 0;
    results_seen  = 0;
    reg_writes    = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_events();
    test_limit_extremes();
    test_back_pressure();
    test_no_idle_stretch();
    test_random_settings();
    drain_block();

    $display("covered %0d events with %0d load queries and %0d results checked,",
             events_sent, queries_sent, results_seen);
    $display("across %0d limit register writes including zero and over-depth limits",
             reg_writes);
    if (fail_count == 0 && expected_loads.size() == 0) begin
      $display("TB_OK");
    end else begin
      if (expected_loads.size() != 0) begin
        $display("%0d load results never arrived", expected_loads.size());
      end
      $display("%0d failures", fail_count);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/wlm_pkg.sv
rtl/core/wlm_if.sv
rtl/core/wlm_ctrl.sv
rtl/core/wlm_datapath.sv
rtl/core/windowed_load_monitor.sv
tb/tb_windowed_load_monitor.sv
